### hdl/holt_winters_seasonal_forecaster_defines.svh
// Assertion macros shared by the forecaster RTL.
// Depends on nothing; the using module must have i_clk and i_rst_n in scope.
`ifndef HOLT_WINTERS_SEASONAL_FORECASTER_DEFINES_SVH
`define HOLT_WINTERS_SEASONAL_FORECASTER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HWSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HWSF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/hwsf_pkg.sv
// Package for the Holt-Winters forecaster: widths, reset values, codes and
// saturation helpers. Depends on nothing.
package hwsf_pkg;

    localparam int SEASON_MAX_DEF     = 1024;
    localparam int PLAIN_INIT_LEN_DEF = 30;

    localparam int DATA_W     = 32;
    localparam int EST_W      = 40;
    localparam int W_W        = 17;
    localparam int SLEN_W     = 11;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [W_W-1:0]    W_ONE          = 17'h10000;
    localparam logic [W_W-1:0]    ALPHA_RST      = 17'd19661;
    localparam logic [W_W-1:0]    BETA_RST       = 17'd6554;
    localparam logic [W_W-1:0]    GAMMA_RST      = 17'd6554;
    localparam logic [SLEN_W-1:0] SEASON_LEN_RST = 11'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA      = 2'd0,
        REG_BETA       = 2'd1,
        REG_GAMMA      = 2'd2,
        REG_SEASON_LEN = 2'd3
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FSUM_RD,
        ST_FSUM_ACC,
        ST_DIV,
        ST_FCTR_RD,
        ST_FCTR_WR,
        ST_FADJ_RD,
        ST_FADJ_WR,
        ST_STEP_RD,
        ST_PRED,
        ST_LVL_MUL,
        ST_LVL_UPD,
        ST_TRD_OP,
        ST_TRD_MUL,
        ST_TRD_UPD,
        ST_SEA_OP
    } t_state;

    // Clamp a wide signed value to the 40-bit estimate range.
    function automatic logic signed [EST_W-1:0] sat_est(input logic signed [63:0] v);
        logic [63-EST_W+1:0] top;
        top = v[63:EST_W-1];
        if (top == '0 || top == '1) begin
            return v[EST_W-1:0];
        end
        return v[63] ? {1'b1, {(EST_W-1){1'b0}}} : {1'b0, {(EST_W-1){1'b1}}};
    endfunction

    // Clamp a wide signed value to the 32-bit output range.
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [63:0] v);
        logic [63-DATA_W+1:0] top;
        top = v[63:DATA_W-1];
        if (top == '0 || top == '1) begin
            return v[DATA_W-1:0];
        end
        return v[63] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    // Smoothing weights above one count as one.
    function automatic logic [W_W-1:0] wsat(input logic [W_W-1:0] w);
        return w[W_W-1] ? W_ONE : w;
    endfunction

endpackage

### hdl/holt_winters_seasonal_forecaster.sv
// Top level of the additive Holt-Winters forecaster (Q16.16 samples).
// Depends on hwsf_pkg, hwsf_ram and holt_winters_seasonal_forecaster_defines.svh.
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_stall    i_func, i_sample, i_sample_missing
//  output    out        o_out_valid / i_out_stall  o_prediction, o_forecast_error,
//                                                  o_error_valid
//  config    in         i_cfg_we                   i_cfg_index, i_cfg_wdata
//
// An init request is taken in the idle state. In a forecast step the level,
// trend and seasonal updates use the single shared multiplier one after
// another; without seasonality the seasonal update is skipped, and a missing
// sample ends the step with the prediction. The first step also finalises
// the state, with a table read per slot and the bit-serial divider.
// Reset is synchronous and active low; no clearing pass is needed. A finished
// result waits in the output register; the step stalls only if it is still held.
`include "holt_winters_seasonal_forecaster_defines.svh"

module holt_winters_seasonal_forecaster #(
    parameter int SEASON_MAX     = hwsf_pkg::SEASON_MAX_DEF,
    parameter int PLAIN_INIT_LEN = hwsf_pkg::PLAIN_INIT_LEN_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_func,
    input  logic signed [hwsf_pkg::DATA_W-1:0]    i_sample,
    input  logic                                  i_sample_missing,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [hwsf_pkg::DATA_W-1:0]    o_prediction,
    output logic signed [hwsf_pkg::DATA_W-1:0]    o_forecast_error,
    output logic                                  o_error_valid,
    input  logic                                  i_cfg_we,
    input  logic [hwsf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [hwsf_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import hwsf_pkg::*;

    // Slot address, count and accumulator widths all follow from SEASON_MAX.
    localparam int AW        = (SEASON_MAX > 1) ? $clog2(SEASON_MAX) : 1;
    localparam int CW        = $clog2(SEASON_MAX + 1);
    localparam int ACC_W     = EST_W + 2 + AW;
    localparam int CNT_W     = $clog2(ACC_W + 1);
    localparam int PLAIN_CAP = (PLAIN_INIT_LEN < SEASON_MAX) ? PLAIN_INIT_LEN : SEASON_MAX;
    localparam int MOP_W     = EST_W + 3;
    localparam int WS_W      = W_W + 1;
    localparam int PROD_W    = MOP_W + WS_W;
    localparam int RAM_W     = EST_W + 1;

    // Configuration registers.
    logic [W_W-1:0]    r_alpha, r_beta, r_gamma;
    logic [SLEN_W-1:0] r_season_len;

    // Control state.
    t_state  r_state, n_state;
    logic    r_finalized, n_finalized;
    logic [CW-1:0] r_init_count, n_init_count;
    logic [AW-1:0] r_phase, n_phase;
    logic    r_on, n_on;
    logic    r_fin_on, n_fin_on;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_vc, n_vc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic    r_div_lvl, n_div_lvl;
    logic    r_out_valid, n_out_valid;
    // Marks the second pass through the multiply states as the seasonal update.
    logic    r_s_phase, n_s_phase;

    // Estimates and working registers.
    logic signed [EST_W-1:0]  r_level, n_level;
    logic signed [EST_W-1:0]  r_trend, n_trend;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic [ACC_W-1:0]         r_dq, n_dq;
    logic [CW:0]              r_rem, n_rem;
    logic                     r_neg, n_neg;
    logic signed [EST_W:0]    r_mean, n_mean;
    logic signed [EST_W:0]    r_base, n_base;
    logic signed [EST_W-1:0]  r_prev, n_prev;
    logic signed [EST_W-1:0]  r_s, n_s;
    logic                     r_abs, n_abs;
    logic signed [DATA_W-1:0] r_x, n_x;
    logic                     r_missing, n_missing;
    logic signed [MOP_W-1:0]  r_mop, n_mop;
    logic signed [EST_W:0]    r_addend, n_addend;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [DATA_W-1:0] r_pred, n_pred;
    logic signed [DATA_W-1:0] r_err, n_err;
    logic                     r_err_valid, n_err_valid;

    // Table memory: seasonal factor (raw sample during init) plus absent flag.
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [RAM_W-1:0] ram_wdata, ram_rdata;

    hwsf_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SEASON_MAX)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Derived control terms.
    logic [CW-1:0] p_eff, cap, fin_n;
    logic          season_on, in_accept, out_free;
    logic [AW-1:0] phase_eff, phase_next;
    logic [31:0]   phase_inc;

    always_comb begin
        if (32'(r_season_len) > 32'(SEASON_MAX)) begin
            p_eff = CW'(SEASON_MAX);
        end else begin
            p_eff = CW'(r_season_len);
        end
    end

    assign season_on = (p_eff != '0) && (r_init_count >= p_eff);
    assign cap       = (p_eff != '0) ? p_eff : CW'(PLAIN_CAP);
    assign fin_n     = season_on ? p_eff :
                       ((r_init_count < CW'(PLAIN_CAP)) ? r_init_count : CW'(PLAIN_CAP));
    assign phase_eff = (!season_on || (32'(r_phase) >= 32'(p_eff))) ? '0 : r_phase;
    assign phase_inc = 32'(r_phase) + 32'd1;
    assign phase_next = !r_on ? r_phase :
                        ((phase_inc >= 32'(p_eff)) ? '0 : AW'(phase_inc));

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // Datapath terms.
    logic signed [EST_W-1:0]  rd_val, rd_s;
    logic signed [EST_W+1:0]  pred_full;
    logic signed [MOP_W-1:0]  err_full;
    logic signed [EST_W-1:0]  upd;
    logic signed [WS_W-1:0]   w_sel;
    logic signed [PROD_W-1:0] mul_res;
    logic signed [EST_W:0]    ctr_t;
    logic signed [EST_W-1:0]  adj_v;
    logic [CW-1:0]            divisor;
    logic [CW:0]              rem_sh;
    logic                     rem_ge;
    logic [ACC_W-1:0]         q_full;

    assign rd_val    = $signed(ram_rdata[EST_W-1:0]);
    assign rd_s      = r_on ? rd_val : '0;
    assign pred_full = (EST_W+2)'(r_base) + (EST_W+2)'(rd_s);
    assign err_full  = MOP_W'(r_x) - MOP_W'(rd_s) - MOP_W'(r_base);
    // Weighted term rounded half up: add one half before the flooring shift.
    assign upd       = sat_est(64'(r_addend) + ((64'(r_prod) + 64'sd32768) >>> FRAC_W));
    assign mul_res   = r_mop * w_sel;
    assign ctr_t     = ram_rdata[EST_W] ? '0 : ((EST_W+1)'(rd_val) - (EST_W+1)'(r_level));
    assign adj_v     = sat_est(64'(rd_val) - 64'(r_mean));

    // The seasonal update reuses the trend multiply slot, with gamma selected.
    always_comb begin
        case (r_state)
            ST_LVL_MUL: w_sel = $signed({1'b0, wsat(r_alpha)});
            ST_TRD_MUL: w_sel = r_s_phase ? $signed({1'b0, wsat(r_gamma)})
                                          : $signed({1'b0, wsat(r_beta)});
            default:    w_sel = $signed({1'b0, wsat(r_gamma)});
        endcase
    end

    // Bit-serial restoring divider on the magnitude; quotient truncates toward zero.
    assign divisor = r_div_lvl ? r_vc : r_n;
    assign rem_sh  = {r_rem[CW-1:0], r_dq[ACC_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, divisor};
    assign q_full  = r_neg ? (~r_dq + 1'b1) : r_dq;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && i_func) begin
                    n_state = r_finalized ? ST_STEP_RD : ST_FSUM_RD;
                end
            end
            ST_FSUM_RD:  n_state = (r_idx == r_n) ? ST_DIV : ST_FSUM_ACC;
            ST_FSUM_ACC: n_state = ST_FSUM_RD;
            ST_DIV: begin
                if (r_cnt == '0) begin
                    if (r_div_lvl) begin
                        n_state = r_fin_on ? ST_FCTR_RD : ST_STEP_RD;
                    end else begin
                        n_state = ST_FADJ_RD;
                    end
                end
            end
            ST_FCTR_RD:  n_state = (r_idx == r_n) ? ST_DIV : ST_FCTR_WR;
            ST_FCTR_WR:  n_state = ST_FCTR_RD;
            ST_FADJ_RD:  n_state = (r_idx == r_n) ? ST_STEP_RD : ST_FADJ_WR;
            ST_FADJ_WR:  n_state = ST_FADJ_RD;
            ST_STEP_RD:  n_state = ST_PRED;
            ST_PRED: begin
                if (out_free) begin
                    n_state = r_missing ? ST_IDLE : ST_LVL_MUL;
                end
            end
            ST_LVL_MUL:  n_state = ST_LVL_UPD;
            ST_LVL_UPD:  n_state = ST_TRD_OP;
            ST_TRD_OP:   n_state = ST_TRD_MUL;
            ST_TRD_MUL:  n_state = ST_TRD_UPD;
            // After the trend pass a seasonal pass follows when seasonality is on.
            ST_TRD_UPD:  n_state = (r_on && !r_s_phase) ? ST_SEA_OP : ST_IDLE;
            ST_SEA_OP:   n_state = ST_TRD_MUL;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_finalized  = r_finalized;
        n_init_count = r_init_count;
        n_phase      = r_phase;
        n_on         = r_on;
        n_fin_on     = r_fin_on;
        n_idx        = r_idx;
        n_n          = r_n;
        n_vc         = r_vc;
        n_cnt        = r_cnt;
        n_div_lvl    = r_div_lvl;
        n_out_valid  = r_out_valid && i_out_stall;
        n_level      = r_level;
        n_trend      = r_trend;
        n_acc        = r_acc;
        n_dq         = r_dq;
        n_rem        = r_rem;
        n_neg        = r_neg;
        n_mean       = r_mean;
        n_base       = r_base;
        n_prev       = r_prev;
        n_s          = r_s;
        n_abs        = r_abs;
        n_x          = r_x;
        n_missing    = r_missing;
        n_mop        = r_mop;
        n_addend     = r_addend;
        n_prod       = r_prod;
        n_pred       = r_pred;
        n_err        = r_err;
        n_err_valid  = r_err_valid;
        n_s_phase    = r_s_phase;
        ram_we       = 1'b0;
        ram_waddr    = r_idx[AW-1:0];
        ram_wdata    = {r_abs, r_s};
        ram_raddr    = r_phase;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_x       = i_sample;
                    n_missing = i_sample_missing;
                    if (!i_func) begin
                        if (!r_finalized && (r_init_count < cap)) begin
                            ram_we       = 1'b1;
                            ram_waddr    = r_init_count[AW-1:0];
                            ram_wdata    = {i_sample_missing, EST_W'(i_sample)};
                            n_init_count = r_init_count + 1'b1;
                        end
                    end else if (!r_finalized) begin
                        n_idx    = '0;
                        n_n      = fin_n;
                        n_fin_on = season_on;
                        n_acc    = '0;
                        n_vc     = '0;
                    end
                end
            end
            ST_FSUM_RD, ST_FCTR_RD: begin
                ram_raddr = r_idx[AW-1:0];
                if (r_idx == r_n) begin
                    n_neg     = r_acc[ACC_W-1];
                    n_dq      = r_acc[ACC_W-1] ? $unsigned(-r_acc) : $unsigned(r_acc);
                    n_rem     = '0;
                    n_cnt     = CNT_W'(ACC_W);
                    n_div_lvl = (r_state == ST_FSUM_RD);
                end
            end
            ST_FSUM_ACC: begin
                if (!ram_rdata[EST_W]) begin
                    n_acc = r_acc + ACC_W'(rd_val);
                    n_vc  = r_vc + 1'b1;
                end
                n_idx = r_idx + 1'b1;
            end
            ST_DIV: begin
                if (r_cnt != '0) begin
                    n_rem = rem_ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
                    n_dq  = {r_dq[ACC_W-2:0], rem_ge};
                    n_cnt = r_cnt - 1'b1;
                end else if (r_div_lvl) begin
                    n_level = (r_vc == '0) ? '0 : $signed(q_full[EST_W-1:0]);
                    n_trend = '0;
                    n_idx   = '0;
                    n_acc   = '0;
                    if (!r_fin_on) begin
                        n_finalized = 1'b1;
                        n_phase     = '0;
                    end
                end else begin
                    n_mean = $signed(q_full[EST_W:0]);
                    n_idx  = '0;
                end
            end
            ST_FCTR_WR: begin
                ram_we    = 1'b1;
                ram_wdata = {ram_rdata[EST_W], ctr_t[EST_W-1:0]};
                n_acc     = r_acc + ACC_W'(ctr_t);
                n_idx     = r_idx + 1'b1;
            end
            ST_FADJ_RD: begin
                ram_raddr = r_idx[AW-1:0];
                if (r_idx == r_n) begin
                    n_finalized = 1'b1;
                    n_phase     = '0;
                end
            end
            ST_FADJ_WR: begin
                ram_we    = 1'b1;
                ram_wdata = {ram_rdata[EST_W], adj_v};
                n_idx     = r_idx + 1'b1;
            end
            ST_STEP_RD: begin
                ram_raddr = phase_eff;
                n_phase   = phase_eff;
                n_on      = season_on;
                n_base    = (EST_W+1)'(r_level) + (EST_W+1)'(r_trend);
                n_prev    = r_level;
                n_s_phase = 1'b0;
            end
            ST_PRED: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_pred      = sat_data(64'(pred_full));
                    n_err       = r_missing ? '0 : sat_data(64'(err_full));
                    n_err_valid = !r_missing;
                    n_s         = rd_s;
                    n_abs       = ram_rdata[EST_W];
                    n_mop       = err_full;
                    n_addend    = r_base;
                    if (r_missing) begin
                        n_phase = phase_next;
                    end
                end
            end
            ST_LVL_MUL, ST_TRD_MUL: begin
                n_prod = mul_res;
            end
            ST_LVL_UPD: begin
                n_level = upd;
            end
            ST_TRD_OP: begin
                n_mop    = MOP_W'(r_level) - MOP_W'(r_prev) - MOP_W'(r_trend);
                n_addend = (EST_W+1)'(r_trend);
            end
            ST_TRD_UPD: begin
                if (r_s_phase) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_phase;
                    ram_wdata = {r_abs, upd};
                    n_phase   = phase_next;
                end else begin
                    n_trend = upd;
                    if (!r_on) begin
                        n_phase = phase_next;
                    end
                end
            end
            ST_SEA_OP: begin
                n_mop     = MOP_W'(r_x) - MOP_W'(r_level) - MOP_W'(r_s);
                n_addend  = (EST_W+1)'(r_s);
                n_s_phase = 1'b1;
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_finalized  <= 1'b0;
            r_init_count <= '0;
            r_phase      <= '0;
            r_on         <= 1'b0;
            r_fin_on     <= 1'b0;
            r_idx        <= '0;
            r_n          <= '0;
            r_vc         <= '0;
            r_cnt        <= '0;
            r_div_lvl    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_s_phase    <= 1'b0;
            r_level      <= '0;
            r_trend      <= '0;
            r_alpha      <= ALPHA_RST;
            r_beta       <= BETA_RST;
            r_gamma      <= GAMMA_RST;
            r_season_len <= SEASON_LEN_RST;
        end else begin
            r_state      <= n_state;
            r_finalized  <= n_finalized;
            r_init_count <= n_init_count;
            r_phase      <= n_phase;
            r_on         <= n_on;
            r_fin_on     <= n_fin_on;
            r_idx        <= n_idx;
            r_n          <= n_n;
            r_vc         <= n_vc;
            r_cnt        <= n_cnt;
            r_div_lvl    <= n_div_lvl;
            r_out_valid  <= n_out_valid;
            r_s_phase    <= n_s_phase;
            r_level      <= n_level;
            r_trend      <= n_trend;
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_ALPHA:      r_alpha      <= i_cfg_wdata[W_W-1:0];
                    REG_BETA:       r_beta       <= i_cfg_wdata[W_W-1:0];
                    REG_GAMMA:      r_gamma      <= i_cfg_wdata[W_W-1:0];
                    REG_SEASON_LEN: r_season_len <= i_cfg_wdata[SLEN_W-1:0];
                    default:        r_alpha      <= r_alpha;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_dq        <= n_dq;
        r_rem       <= n_rem;
        r_neg       <= n_neg;
        r_mean      <= n_mean;
        r_base      <= n_base;
        r_prev      <= n_prev;
        r_s         <= n_s;
        r_abs       <= n_abs;
        r_x         <= n_x;
        r_missing   <= n_missing;
        r_mop       <= n_mop;
        r_addend    <= n_addend;
        r_prod      <= n_prod;
        r_pred      <= n_pred;
        r_err       <= n_err;
        r_err_valid <= n_err_valid;
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_prediction     = r_pred;
    assign o_forecast_error = r_err;
    assign o_error_valid    = r_err_valid;

    `HWSF_ASSERT_NXT(a_lvl_seq, r_state == ST_LVL_MUL, r_state == ST_LVL_UPD, "level multiply lost its update")
    `HWSF_ASSERT_IMP(a_out_fin, o_out_valid, r_finalized, "result issued before finalisation")
    `HWSF_ASSERT_IMP(a_ram_we, ram_we, r_state == ST_IDLE || r_state == ST_FCTR_WR || r_state == ST_FADJ_WR || r_state == ST_TRD_UPD, "table written outside a write state")
    `HWSF_ASSERT_IMP(a_sea_on, r_s_phase && r_state == ST_TRD_UPD, r_on, "seasonal update without seasonality")

endmodule

### hdl/hwsf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module hwsf_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### tb/tb.sv
// Self-checking testbench for the additive Holt-Winters forecaster.
// Depends on hwsf_pkg and holt_winters_seasonal_forecaster; it predicts every
// step in fixed point and compares the forecasts that come back in order.
module tb;
    import hwsf_pkg::*;

    // Clock, reset and every input of the block start at a known value.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_func = 1'b0;
    logic signed [DATA_W-1:0] i_sample = '0;
    logic i_sample_missing = 1'b0;
    logic i_out_stall = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic o_in_stall;
    logic o_out_valid;
    logic signed [DATA_W-1:0] o_prediction;
    logic signed [DATA_W-1:0] o_forecast_error;
    logic o_error_valid;

    holt_winters_seasonal_forecaster u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_func(i_func), .i_sample(i_sample), .i_sample_missing(i_sample_missing),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_prediction(o_prediction), .o_forecast_error(o_forecast_error),
        .o_error_valid(o_error_valid),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    typedef struct packed {
        logic func;
        logic signed [DATA_W-1:0] sample;
        logic missing;
    } t_request;

    typedef struct packed {
        logic signed [DATA_W-1:0] prediction;
        logic signed [DATA_W-1:0] fc_error;
        logic err_valid;
    } t_forecast;

    t_request  pending_requests[$];
    t_forecast due_forecasts[$];

    int send_idle = 0;
    int recv_idle = 0;
    int mismatches = 0;
    int steps_seen = 0;
    int requests_sent = 0;

    // Our own copy of the configuration and of the forecaster state.
    logic [W_W-1:0]    w_alpha = ALPHA_RST;
    logic [W_W-1:0]    w_beta  = BETA_RST;
    logic [W_W-1:0]    w_gamma = GAMMA_RST;
    logic [SLEN_W-1:0] slen    = SEASON_LEN_RST;

    longint lvl_m, trd_m;
    longint factors[SEASON_MAX_DEF];
    bit     slot_gap[SEASON_MAX_DEF];
    int     n_init, phase_m;
    bit     ready_m;

    function automatic longint clamp(input longint v, input int bits);
        longint hi, lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // Weighted term, rounded half up; the arithmetic shift floors.
    function automatic longint weigh(input logic [W_W-1:0] w, input longint v);
        longint wl;
        wl = w > W_ONE ? longint'(W_ONE) : longint'(w);
        return (v * wl + 32768) >>> FRAC_W;
    endfunction

    function automatic int eff_period();
        return slen > SEASON_MAX_DEF ? SEASON_MAX_DEF : int'(slen);
    endfunction

    function automatic bit seasonal();
        return eff_period() > 0 && n_init >= eff_period();
    endfunction

    // First step: the level is the mean of present samples, and the seasonal
    // slots become centred deviations from it.
    task automatic settle_init();
        int p, n, vc;
        longint acc, ssum, centre;
        bit on;
        p = eff_period();
        on = seasonal();
        vc = 0;
        acc = 0;
        ssum = 0;
        n = on ? p : (n_init < PLAIN_INIT_LEN_DEF ? n_init : PLAIN_INIT_LEN_DEF);
        for (int i = 0; i < n; i++) begin
            if (!slot_gap[i]) begin
                acc += factors[i];
                vc++;
            end
        end
        lvl_m = vc > 0 ? acc / vc : 0;
        trd_m = 0;
        if (on) begin
            for (int i = 0; i < p; i++) begin
                factors[i] = slot_gap[i] ? 0 : factors[i] - lvl_m;
                ssum += factors[i];
            end
            centre = ssum / p;
            for (int i = 0; i < p; i++) factors[i] = clamp(factors[i] - centre, EST_W);
        end
        phase_m = 0;
        ready_m = 1'b1;
    endtask

    task automatic forecast_request(input t_request r);
        longint x, s, pred, prev, base, lvl;
        int p, cap;
        bit on;
        t_forecast f;
        x = longint'(r.sample);
        s = 0;
        p = eff_period();
        if (!r.func) begin
            cap = p > 0 ? p : PLAIN_INIT_LEN_DEF;
            if (!ready_m && n_init < cap) begin
                factors[n_init] = x;
                slot_gap[n_init] = r.missing;
                n_init++;
            end
            return;
        end
        if (!ready_m) settle_init();
        on = seasonal();
        if (!on || phase_m >= p) phase_m = 0;
        if (on) s = factors[phase_m];
        pred = lvl_m + trd_m + s;
        f.prediction = DATA_W'(clamp(pred, DATA_W));
        if (r.missing) begin
            f.fc_error = '0;
            f.err_valid = 1'b0;
        end else begin
            f.fc_error = DATA_W'(clamp(x - pred, DATA_W));
            f.err_valid = 1'b1;
            prev = lvl_m;
            base = lvl_m + trd_m;
            lvl = clamp(base + weigh(w_alpha, (x - s) - base), EST_W);
            lvl_m = lvl;
            trd_m = clamp(trd_m + weigh(w_beta, (lvl - prev) - trd_m), EST_W);
            if (on) factors[phase_m] = clamp(s + weigh(w_gamma, (x - lvl) - s), EST_W);
        end
        if (on) phase_m = (phase_m + 1 >= p) ? 0 : phase_m + 1;
        due_forecasts = {due_forecasts, f};
    endtask

    // Driver: a request is predicted at the edge that accepts it. The payload
    // only moves on when the block is not stalling.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                forecast_request('{i_func, i_sample, i_sample_missing});
                requests_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle) begin
                    t_request r;
                    r = pending_requests.pop_front();
                    i_func <= r.func;
                    i_sample <= r.sample;
                    i_sample_missing <= r.missing;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: back-pressure at random, and check each forecast in order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_out_stall <= ($urandom_range(99) < recv_idle);
            if (o_out_valid && !i_out_stall) begin
                steps_seen++;
                if (due_forecasts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected forecast pred=%0d", o_prediction);
                end else begin
                    t_forecast f;
                    f = due_forecasts.pop_front();
                    if (o_prediction !== f.prediction || o_forecast_error !== f.fc_error ||
                        o_error_valid !== f.err_valid) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("forecast mismatch: expected pred=%0d err=%0d ev=%0b",
                                     f.prediction, f.fc_error, f.err_valid);
                            $display("                   actual   pred=%0d err=%0d ev=%0b",
                                     o_prediction, o_forecast_error, o_error_valid);
                        end
                    end
                end
            end
        end
    end

    task automatic queue_request(input logic func, input logic signed [DATA_W-1:0] v,
                                 input logic missing);
        t_request r;
        r = '{func, v, missing};
        pending_requests = {pending_requests, r};
    endtask

    // Mostly moderate values so that the smoothing stays meaningful, with
    // full-range values and the extremes mixed in.
    function automatic logic signed [DATA_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6) return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
        if (sel < 8) return $urandom;
        return sel == 8 ? 32'sh7fff_ffff : 32'sh8000_0000;
    endfunction

    // Waits until everything sent has been answered, then lets any trailing
    // work inside the block finish before the registers move.
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_requests.size() > 0 || i_in_valid || due_forecasts.size() > 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_weights(input logic [W_W-1:0] a, input logic [W_W-1:0] b,
                               input logic [W_W-1:0] g, input logic [SLEN_W-1:0] s);
        logic [CFG_DATA_W-1:0] vals[4];
        t_cfg_reg regs[4];
        vals = '{a, b, g, CFG_DATA_W'(s)};
        regs = '{REG_ALPHA, REG_BETA, REG_GAMMA, REG_SEASON_LEN};
        for (int i = 0; i < 4; i++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_wdata <= vals[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        w_alpha = a;
        w_beta = b;
        w_gamma = g;
        slen = s;
    endtask

    initial begin
        logic [W_W-1:0] cfg_a[9], cfg_b[9], cfg_g[9];
        logic [SLEN_W-1:0] cfg_s[9];
        lvl_m = 0;
        trd_m = 0;
        n_init = 0;
        phase_m = 0;
        ready_m = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Settings per phase: extremes of every weight, oversized weights,
        // plain mode, a period longer than the stored season and short ones.
        cfg_a = '{17'd19661, 17'd0, 17'h10000, 17'h1ffff, 17'd30000, 17'd40000,
                  17'd5000, 17'd65535, 17'd12345};
        cfg_b = '{17'd6554, 17'd0, 17'h10000, 17'd100000, 17'd3000, 17'd20000,
                  17'd1, 17'd60000, 17'd777};
        cfg_g = '{17'd6554, 17'd0, 17'h10000, 17'd70000, 17'd50000, 17'd9000,
                  17'd65536, 17'd2, 17'd33333};
        cfg_s = '{11'd8, 11'd8, 11'd8, 11'd4, 11'd0, 11'd2047, 11'd3, 11'd1, 11'd8};

        for (int ph = 0; ph < 9; ph++) begin
            send_idle = (ph < 3) ? 14 : (ph < 6) ? 88 : 0;
            recv_idle = (ph < 3) ? 88 : (ph < 6) ? 14 : 0;
            set_weights(cfg_a[ph], cfg_b[ph], cfg_g[ph], cfg_s[ph]);
            if (ph == 0) begin
                // One season of eight, two of them missing, then two extra
                // samples that the full table ignores.
                queue_request(1'b0, 32'sh7fff_ffff, 1'b0);
                queue_request(1'b0, 32'sh8000_0000, 1'b0);
                queue_request(1'b0, 32'sh0001_0000, 1'b1);
                queue_request(1'b0, 32'sh0000_0000, 1'b0);
                queue_request(1'b0, 32'sh0003_8000, 1'b0);
                queue_request(1'b0, -32'sh0002_4000, 1'b0);
                queue_request(1'b0, 32'sh5555_aaaa, 1'b1);
                queue_request(1'b0, 32'sh0010_0000, 1'b0);
                queue_request(1'b0, 32'sh0123_4567, 1'b0);
                queue_request(1'b0, -32'sh0123_4567, 1'b0);
                // First step finalises; then a missing step, extremes, and an
                // init sample after finalisation, which produces nothing.
                queue_request(1'b1, 32'sh0002_0000, 1'b0);
                queue_request(1'b1, 32'sh0002_0000, 1'b1);
                queue_request(1'b1, 32'sh7fff_ffff, 1'b0);
                queue_request(1'b1, 32'sh8000_0000, 1'b0);
                queue_request(1'b0, 32'sh0004_0000, 1'b0);
                queue_request(1'b1, 32'shffff_ffff, 1'b0);
                queue_request(1'b1, 32'sh0000_0000, 1'b0);
                queue_request(1'b1, 32'shaaaa_5555, 1'b1);
            end
            for (int i = 0; i < 195; i++) begin
                queue_request($urandom_range(19) != 0, pick_sample(),
                              $urandom_range(9) == 0);
            end
            // Every phase ends by waiting until all that was sent is answered.
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (due_forecasts.size() > 0) mismatches += due_forecasts.size();
        $display("covered %0d requests and %0d forecast steps over nine weight settings",
                 requests_sent, steps_seen);
        $display("seasonal, plain and over-long periods, with both sides idling");
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/hwsf_pkg.sv
hdl/hwsf_ram.sv
hdl/holt_winters_seasonal_forecaster.sv
tb/tb.sv
